>>> rtl/irv_pkg.sv
// ----------------------------------------------------------------------------
// Image receive verifier package
// Shared opcodes, status codes, register indexes, the result record and the
// byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package irv_pkg;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_DATA   = 2'd1,
      OP_FINISH = 2'd2,
      OP_ABORT  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ARG   = 3'd1,
      ST_BAD_STATE = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_SHORT     = 3'd4,
      ST_CRC_BAD   = 3'd5
   } status_type;

   localparam logic REG_EXPECTED_LENGTH = 1'b0;
   localparam logic REG_EXPECTED_CRC    = 1'b1;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [23:0] bytes_received;
      logic [31:0] crc_value;
      status_type  status;
   } result_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/irv_step.sv
// ----------------------------------------------------------------------------
// Image receive verifier session step
// Decodes one item against the session state and the live registers, and
// produces the next state together with the result record.
// ----------------------------------------------------------------------------
module irv_step #(
   parameter int LENGTH_BITS = 24
) (
   input  irv_pkg::opcode_type      opcode,
   input  logic [7:0]               data_byte,
   input  logic                     session_open,
   input  logic [31:0]              running_crc,
   input  logic [LENGTH_BITS-1:0]   byte_count,
   input  logic [LENGTH_BITS-1:0]   expected_length,
   input  logic [31:0]              expected_crc,
   output logic                     session_open_in,
   output logic [31:0]              running_crc_in,
   output logic [LENGTH_BITS-1:0]   byte_count_in,
   output irv_pkg::result_type      result
);

   irv_pkg::status_type status;

   always_comb begin
      status          = irv_pkg::ST_OK;
      session_open_in = session_open;
      running_crc_in  = running_crc;
      byte_count_in   = byte_count;
      unique case (opcode)
         irv_pkg::OP_START: begin
            if (expected_length == '0) begin
               status = irv_pkg::ST_BAD_ARG;
            end else if (session_open) begin
               status = irv_pkg::ST_BAD_STATE;
            end else begin
               session_open_in = 1'b1;
               running_crc_in  = irv_pkg::CRC_INIT;
               byte_count_in   = '0;
            end
         end
         irv_pkg::OP_DATA: begin
            if (!session_open) begin
               status = irv_pkg::ST_BAD_ARG;
            end else if (byte_count >= expected_length) begin
               status = irv_pkg::ST_OVERFLOW;
            end else begin
               byte_count_in  = byte_count + LENGTH_BITS'(1);
               running_crc_in = irv_pkg::crc32_byte(running_crc, data_byte);
            end
         end
         irv_pkg::OP_FINISH: begin
            if (!session_open) begin
               status = irv_pkg::ST_BAD_STATE;
            end else begin
               if (byte_count != expected_length) begin
                  status = irv_pkg::ST_SHORT;
               end else if ((expected_crc != 32'd0) && (~running_crc != expected_crc)) begin
                  status = irv_pkg::ST_CRC_BAD;
               end
               session_open_in = 1'b0;
            end
         end
         irv_pkg::OP_ABORT: begin
            session_open_in = 1'b0;
         end
         default: begin
            session_open_in = session_open;
         end
      endcase
   end

   assign result.status         = status;
   assign result.crc_value      = ~running_crc_in;
   assign result.bytes_received = 24'(byte_count_in);

endmodule

>>> rtl/image_receive_verifier.sv
// ----------------------------------------------------------------------------
// Image receive verifier
// Each result is registered in the output stage when its item is accepted.
// Throughput: one item per cycle while the skid entry is empty, set by the
// byte-wide CRC-32 update in the session step logic; a two-entry output
// stage keeps req_tready registered. Reset is synchronous: no session, CRC
// all ones, count and registers zero, and the output stage empty.
// ----------------------------------------------------------------------------
module image_receive_verifier #(
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] crc_value, [55:32] bytes_received
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                   session_open_ff;
   logic                   session_open_in;
   logic [31:0]            running_crc_ff;
   logic [31:0]            running_crc_in;
   logic [LENGTH_BITS-1:0] byte_count_ff;
   logic [LENGTH_BITS-1:0] byte_count_in;
   logic [LENGTH_BITS-1:0] expected_length_ff;
   logic [31:0]            expected_crc_ff;
   logic                   rsp_valid_ff;
   logic                   skid_valid_ff;
   irv_pkg::result_type    rsp_data_ff;
   irv_pkg::result_type    skid_data_ff;
   irv_pkg::result_type    step_result;
   logic                   req_accept;
   logic                   csr_write;
   logic                   load_rsp;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign load_rsp   = !rsp_valid_ff || rsp_tready;

   irv_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .opcode          (irv_pkg::opcode_type'(req_tuser)),
      .data_byte       (req_tdata),
      .session_open    (session_open_ff),
      .running_crc     (running_crc_ff),
      .byte_count      (byte_count_ff),
      .expected_length (expected_length_ff),
      .expected_crc    (expected_crc_ff),
      .session_open_in (session_open_in),
      .running_crc_in  (running_crc_in),
      .byte_count_in   (byte_count_in),
      .result          (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         session_open_ff    <= 1'b0;
         running_crc_ff     <= irv_pkg::CRC_INIT;
         byte_count_ff      <= '0;
         expected_length_ff <= '0;
         expected_crc_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (req_accept) begin
            session_open_ff <= session_open_in;
            running_crc_ff  <= running_crc_in;
            byte_count_ff   <= byte_count_in;
         end
         if (csr_write) begin
            unique case (csr_paddr[2])
               irv_pkg::REG_EXPECTED_LENGTH: begin
                  expected_length_ff <= LENGTH_BITS'(csr_pwdata[23:0]);
               end
               irv_pkg::REG_EXPECTED_CRC: begin
                  expected_crc_ff <= csr_pwdata;
               end
               default: begin
                  expected_crc_ff <= expected_crc_ff;
               end
            endcase
         end
         if (req_accept) begin
            if (load_rsp) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_valid_ff && rsp_tready) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (load_rsp) begin
            rsp_data_ff <= step_result;
         end else begin
            skid_data_ff <= step_result;
         end
      end else if (rsp_valid_ff && rsp_tready && skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         irv_pkg::REG_EXPECTED_LENGTH: csr_prdata = 32'(expected_length_ff);
         irv_pkg::REG_EXPECTED_CRC:    csr_prdata = expected_crc_ff;
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.bytes_received, rsp_data_ff.crc_value};
   assign rsp_tuser  = rsp_data_ff.status;

endmodule

>>> rtl/irv_checker.sv
// ----------------------------------------------------------------------------
// Image receive verifier port checker
// Checks the item channels of the top level over time and binds to it.
// ----------------------------------------------------------------------------
module irv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result item changed or dropped.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result item present after reset.");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid)
      else $error("Accepted item produced no result on the next cycle.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= irv_pkg::ST_CRC_BAD)
      else $error("Result item carries an undefined status code.");

endmodule

bind image_receive_verifier irv_checker u_irv_checker (.*);
